>>> design/lcdst_pkg.sv
package lcdst_pkg;

    localparam logic [9:0] DOTS_PER_LINE     = 10'd456;
    localparam logic [7:0] LINES_PER_FRAME   = 8'd154;
    localparam logic [7:0] FIRST_VBLANK_LINE = 8'd144;
    localparam logic [7:0] LAST_VISIBLE_LINE = 8'd143;
    localparam logic [7:0] LAST_LINE         = 8'd153;
    localparam logic [9:0] DOT_BIAS          = 10'd1;
    localparam logic [9:0] OAM_END           = 10'd80 + DOT_BIAS;
    localparam logic [9:0] EARLY_OAM_DOT     = DOTS_PER_LINE - 10'd8 + DOT_BIAS;
    localparam logic [9:0] RESTART_DOT       = 10'd4;
    localparam logic [9:0] LY_ZERO_DOT       = 10'd4;

    localparam int EN_HBLANK = 0;
    localparam int EN_VBLANK = 1;
    localparam int EN_OAM    = 2;
    localparam int EN_LYC    = 3;

    typedef enum logic [1:0] {
        MODE_HBLANK = 2'd0,
        MODE_VBLANK = 2'd1,
        MODE_OAM    = 2'd2,
        MODE_DRAW   = 2'd3
    } t_mode;

    typedef struct packed {
        logic       lcd_enable;
        logic [7:0] dots;
        logic [7:0] lyc_value;
        logic [7:0] wy_value;
        logic [3:0] stat_enables;
        logic       stat_written;
        logic       pixel_done;
        logic       window_used;
    } t_item;

    typedef struct packed {
        logic [7:0] line_value;
        t_mode      lcd_mode;
        logic       lyc_match;
        logic       vblank_irq;
        logic       stat_irq;
        logic       start_line;
        logic       run_dot;
        logic       hblank_entry;
        logic [7:0] window_row_count;
        logic       window_y_latched;
        logic       panel_blank;
    } t_result;

    typedef struct packed {
        logic [9:0] dot_in_line;
        logic [7:0] line_count;
        logic       lcd_running;
        logic       first_line_after_on;
        logic       panel_cleared;
        logic       drawing;
        t_mode      previous_mode;
        logic [7:0] window_row;
        logic       stat_level;
        logic       window_y_hit;
        logic       lyc_match_held;
    } t_state;

endpackage

>>> design/lcdst_step.sv
module lcdst_step (
    input  lcdst_pkg::t_state  i_state,
    input  logic               i_colour_timing,
    input  lcdst_pkg::t_item   i_item,
    output lcdst_pkg::t_state  o_state,
    output lcdst_pkg::t_result o_result
);

    always_comb begin
        lcdst_pkg::t_state  n_st;
        lcdst_pkg::t_result res;
        logic [9:0]         dot_sum;
        logic [7:0]         line_inc;
        logic [7:0]         ly;
        logic               coinc;
        logic               oam_src;
        logic               hblank_src;
        logic               level;
        logic               was_drawing;
        lcdst_pkg::t_mode   mode;

        n_st        = i_state;
        res         = '0;
        dot_sum     = '0;
        line_inc    = '0;
        ly          = '0;
        coinc       = 1'b0;
        oam_src     = 1'b0;
        hblank_src  = 1'b0;
        level       = 1'b0;
        was_drawing = 1'b0;
        mode        = lcdst_pkg::MODE_HBLANK;

        if (!i_item.lcd_enable) begin
            n_st.dot_in_line   = '0;
            n_st.line_count    = '0;
            n_st.window_row    = '0;
            n_st.window_y_hit  = 1'b0;
            n_st.drawing       = 1'b0;
            n_st.stat_level    = i_item.stat_enables[lcdst_pkg::EN_LYC]
                                 && i_state.lyc_match_held;
            n_st.previous_mode = lcdst_pkg::MODE_HBLANK;
            n_st.lcd_running   = 1'b0;
            if (!i_state.panel_cleared) begin
                n_st.panel_cleared = 1'b1;
                res.panel_blank    = 1'b1;
            end
        end else begin
            if (!i_state.lcd_running) begin
                n_st.lcd_running         = 1'b1;
                n_st.panel_cleared       = 1'b0;
                n_st.dot_in_line         = lcdst_pkg::RESTART_DOT;
                n_st.first_line_after_on = 1'b1;
            end

            dot_sum = n_st.dot_in_line + {2'b00, i_item.dots};
            if (dot_sum >= lcdst_pkg::DOTS_PER_LINE) begin
                n_st.dot_in_line         = dot_sum - lcdst_pkg::DOTS_PER_LINE;
                line_inc                 = i_state.line_count + 8'd1;
                n_st.first_line_after_on = 1'b0;
                if (line_inc >= lcdst_pkg::LINES_PER_FRAME) begin
                    n_st.line_count   = '0;
                    n_st.window_row   = '0;
                    n_st.window_y_hit = 1'b0;
                end else begin
                    n_st.line_count = line_inc;
                end
                res.vblank_irq = (n_st.line_count == lcdst_pkg::FIRST_VBLANK_LINE);
            end else begin
                n_st.dot_in_line = dot_sum;
            end

            ly = (n_st.line_count == lcdst_pkg::LAST_LINE
                  && n_st.dot_in_line >= lcdst_pkg::LY_ZERO_DOT) ? 8'd0 : n_st.line_count;
            coinc               = (ly == i_item.lyc_value);
            n_st.lyc_match_held = coinc;

            if (n_st.line_count < lcdst_pkg::FIRST_VBLANK_LINE
                && n_st.dot_in_line < lcdst_pkg::OAM_END && ly == i_item.wy_value) begin
                n_st.window_y_hit = 1'b1;
            end

            if (n_st.line_count < lcdst_pkg::FIRST_VBLANK_LINE
                && n_st.dot_in_line == lcdst_pkg::OAM_END) begin
                res.start_line = 1'b1;
                n_st.drawing   = 1'b1;
            end

            was_drawing = n_st.drawing;
            if (i_item.dots != 8'd0 && n_st.line_count < lcdst_pkg::FIRST_VBLANK_LINE
                && n_st.drawing) begin
                res.run_dot = 1'b1;
                if (i_item.pixel_done) begin
                    n_st.drawing = 1'b0;
                end
            end

            if (n_st.line_count >= lcdst_pkg::FIRST_VBLANK_LINE) begin
                mode = lcdst_pkg::MODE_VBLANK;
            end else if (n_st.dot_in_line < lcdst_pkg::OAM_END) begin
                mode = lcdst_pkg::MODE_OAM;
            end else if (was_drawing) begin
                mode = lcdst_pkg::MODE_DRAW;
            end else begin
                mode = lcdst_pkg::MODE_HBLANK;
            end
            if (n_st.first_line_after_on && mode == lcdst_pkg::MODE_OAM) begin
                mode = lcdst_pkg::MODE_HBLANK;
            end

            oam_src = (mode == lcdst_pkg::MODE_OAM)
                      || (n_st.line_count == lcdst_pkg::FIRST_VBLANK_LINE
                          && n_st.dot_in_line < lcdst_pkg::OAM_END)
                      || (i_colour_timing
                          && n_st.line_count == lcdst_pkg::LAST_VISIBLE_LINE
                          && n_st.dot_in_line >= lcdst_pkg::EARLY_OAM_DOT);
            hblank_src = n_st.line_count < lcdst_pkg::FIRST_VBLANK_LINE && !n_st.drawing
                         && n_st.dot_in_line >= lcdst_pkg::OAM_END;

            level = (hblank_src && i_item.stat_enables[lcdst_pkg::EN_HBLANK])
                    || (mode == lcdst_pkg::MODE_VBLANK
                        && i_item.stat_enables[lcdst_pkg::EN_VBLANK])
                    || (oam_src && i_item.stat_enables[lcdst_pkg::EN_OAM])
                    || (coinc && i_item.stat_enables[lcdst_pkg::EN_LYC]);

            res.stat_irq = !i_state.stat_level
                           && (level || (i_item.stat_written
                               && (hblank_src || mode == lcdst_pkg::MODE_VBLANK || coinc)));
            n_st.stat_level = level;

            if (mode == lcdst_pkg::MODE_HBLANK
                && i_state.previous_mode != lcdst_pkg::MODE_HBLANK
                && n_st.line_count < lcdst_pkg::FIRST_VBLANK_LINE) begin
                res.hblank_entry = 1'b1;
                if (i_item.window_used) begin
                    n_st.window_row = n_st.window_row + 8'd1;
                end
            end
            n_st.previous_mode = mode;

            res.line_value = ly;
            res.lcd_mode   = mode;
        end

        res.lyc_match        = n_st.lyc_match_held;
        res.window_row_count = n_st.window_row;
        res.window_y_latched = n_st.window_y_hit;

        o_state  = n_st;
        o_result = res;
    end

endmodule

>>> design/lcd_scanline_mode_stat_timing_unit.sv
// LCD scanline timing and STAT interrupt controller. Each accepted item advances the dot
// counter of a 456-dot by 154-line frame by its dot count and yields exactly one result item
// with LY, the mode, the coincidence flag, interrupt pulses and pixel pipeline controls. An
// item is registered on entry and its result is registered on exit, with the frame state
// updated in the single stage between them, so one item is accepted every clock unless the
// result side stalls. A stall on the result side holds the result register and, once the
// input register is also full, stalls the input. The colour timing register may only be
// written while no item is in flight.
module lcd_scanline_mode_stat_timing_unit (
    input  logic       i_clk,
    input  logic       i_rst_n,

    input  logic       i_cfg_valid,
    output logic       o_cfg_ready,
    input  logic       i_cfg_colour_timing,

    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  logic       i_lcd_enable,
    input  logic [7:0] i_dots,
    input  logic [7:0] i_lyc_value,
    input  logic [7:0] i_wy_value,
    input  logic [3:0] i_stat_enables,
    input  logic       i_stat_written,
    input  logic       i_pixel_done,
    input  logic       i_window_used,

    output logic       o_out_valid,
    input  logic       i_out_stall,
    output logic [7:0] o_line_value,
    output logic [1:0] o_lcd_mode,
    output logic       o_lyc_match,
    output logic       o_vblank_irq,
    output logic       o_stat_irq,
    output logic       o_start_line,
    output logic       o_run_dot,
    output logic       o_hblank_entry,
    output logic [7:0] o_window_row_count,
    output logic       o_window_y_latched,
    output logic       o_panel_blank
);

    logic                r_colour_timing;
    logic                r_in_valid;
    lcdst_pkg::t_item    r_in;
    logic                r_out_valid;
    lcdst_pkg::t_result  r_out;
    lcdst_pkg::t_state   r_state;
    lcdst_pkg::t_state   n_state;
    lcdst_pkg::t_result  n_out;
    lcdst_pkg::t_item    in_item;
    logic                advance;
    logic                in_accept;

    assign o_cfg_ready = 1'b1;

    assign advance    = r_in_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall = r_in_valid && !advance;
    assign in_accept  = i_in_valid && !o_in_stall;

    always_comb begin
        in_item.lcd_enable   = i_lcd_enable;
        in_item.dots         = i_dots;
        in_item.lyc_value    = i_lyc_value;
        in_item.wy_value     = i_wy_value;
        in_item.stat_enables = i_stat_enables;
        in_item.stat_written = i_stat_written;
        in_item.pixel_done   = i_pixel_done;
        in_item.window_used  = i_window_used;
    end

    lcdst_step u_step (
        .i_state         (r_state),
        .i_colour_timing (r_colour_timing),
        .i_item          (r_in),
        .o_state         (n_state),
        .o_result        (n_out)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_colour_timing <= 1'b0;
            r_in_valid      <= 1'b0;
            r_out_valid     <= 1'b0;
            r_state         <= '0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                r_colour_timing <= i_cfg_colour_timing;
            end
            if (in_accept) begin
                r_in_valid <= 1'b1;
            end else if (advance) begin
                r_in_valid <= 1'b0;
            end
            if (advance) begin
                r_out_valid <= 1'b1;
                r_state     <= n_state;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_in <= in_item;
        end
        if (advance) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid        = r_out_valid;
    assign o_line_value       = r_out.line_value;
    assign o_lcd_mode         = r_out.lcd_mode;
    assign o_lyc_match        = r_out.lyc_match;
    assign o_vblank_irq       = r_out.vblank_irq;
    assign o_stat_irq         = r_out.stat_irq;
    assign o_start_line       = r_out.start_line;
    assign o_run_dot          = r_out.run_dot;
    assign o_hblank_entry     = r_out.hblank_entry;
    assign o_window_row_count = r_out.window_row_count;
    assign o_window_y_latched = r_out.window_y_latched;
    assign o_panel_blank      = r_out.panel_blank;

    // The dot counter always stays inside one line.
    a_dot_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state.dot_in_line < lcdst_pkg::DOTS_PER_LINE)
        else $error("dot counter left the line");

    // The vblank pulse only comes with the first vblank line.
    a_vblank_line: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_vblank_irq) |->
        (o_line_value == lcdst_pkg::FIRST_VBLANK_LINE
         && o_lcd_mode == lcdst_pkg::MODE_VBLANK))
        else $error("vblank pulse outside line 144");

    // Drawing starts in the drawing mode.
    a_start_draw: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_start_line) |-> o_lcd_mode == lcdst_pkg::MODE_DRAW)
        else $error("line start outside drawing mode");

    // Hblank entry reports the hblank mode.
    a_hblank_entry: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_hblank_entry) |-> o_lcd_mode == lcdst_pkg::MODE_HBLANK)
        else $error("hblank entry outside hblank");

    // A panel clear comes from an item with the display off.
    a_panel_blank_off: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_panel_blank) |->
        (o_lcd_mode == lcdst_pkg::MODE_HBLANK && o_line_value == 8'd0 && !o_stat_irq
         && !o_run_dot && !o_window_y_latched))
        else $error("panel clear while the display runs");

endmodule

>>> tb/sv/lcd_scanline_mode_stat_timing_unit_tb.sv
module lcd_scanline_mode_stat_timing_unit_tb;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;

    logic       i_cfg_valid = 1'b0;
    logic       o_cfg_ready;
    logic       i_cfg_colour_timing = 1'b0;

    logic       i_in_valid = 1'b0;
    logic       o_in_stall;
    logic       i_lcd_enable = 1'b0;
    logic [7:0] i_dots = 8'd0;
    logic [7:0] i_lyc_value = 8'd0;
    logic [7:0] i_wy_value = 8'd0;
    logic [3:0] i_stat_enables = 4'd0;
    logic       i_stat_written = 1'b0;
    logic       i_pixel_done = 1'b0;
    logic       i_window_used = 1'b0;

    logic       o_out_valid;
    logic       i_out_stall = 1'b0;
    logic [7:0] o_line_value;
    logic [1:0] o_lcd_mode;
    logic       o_lyc_match;
    logic       o_vblank_irq;
    logic       o_stat_irq;
    logic       o_start_line;
    logic       o_run_dot;
    logic       o_hblank_entry;
    logic [7:0] o_window_row_count;
    logic       o_window_y_latched;
    logic       o_panel_blank;

    lcd_scanline_mode_stat_timing_unit uut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cfg_valid        (i_cfg_valid),
        .o_cfg_ready        (o_cfg_ready),
        .i_cfg_colour_timing(i_cfg_colour_timing),
        .i_in_valid         (i_in_valid),
        .o_in_stall         (o_in_stall),
        .i_lcd_enable       (i_lcd_enable),
        .i_dots             (i_dots),
        .i_lyc_value        (i_lyc_value),
        .i_wy_value         (i_wy_value),
        .i_stat_enables     (i_stat_enables),
        .i_stat_written     (i_stat_written),
        .i_pixel_done       (i_pixel_done),
        .i_window_used      (i_window_used),
        .o_out_valid        (o_out_valid),
        .i_out_stall        (i_out_stall),
        .o_line_value       (o_line_value),
        .o_lcd_mode         (o_lcd_mode),
        .o_lyc_match        (o_lyc_match),
        .o_vblank_irq       (o_vblank_irq),
        .o_stat_irq         (o_stat_irq),
        .o_start_line       (o_start_line),
        .o_run_dot          (o_run_dot),
        .o_hblank_entry     (o_hblank_entry),
        .o_window_row_count (o_window_row_count),
        .o_window_y_latched (o_window_y_latched),
        .o_panel_blank      (o_panel_blank)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    lcdst_pkg::t_item   pending_ticks[$];
    lcdst_pkg::t_result expected_results[$];
    int      n_fail = 0;
    int      n_accepted = 0;
    logic    in_fire = 1'b0;
    logic    quiet;
    int      hold_left = 0;
    logic    hold_done = 1'b0;

    assign quiet = (n_accepted >= 700) && (n_accepted < 900);

    // Frame state of the timing unit as predicted.
    logic       m_colour = 1'b0;
    logic [9:0] m_dot = '0;
    logic [7:0] m_line = '0;
    logic       m_running = 1'b0;
    logic       m_first = 1'b0;
    logic       m_cleared = 1'b0;
    logic       m_drawing = 1'b0;
    lcdst_pkg::t_mode m_prev = lcdst_pkg::MODE_HBLANK;
    logic [7:0] m_wrow = '0;
    logic       m_level = 1'b0;
    logic       m_wy_hit = 1'b0;
    logic       m_lyc_held = 1'b0;

    // Position of the frame counters as seen by the stimulus generator.
    int         p_dot = 0;
    int         p_line = 0;
    logic       p_running = 1'b0;
    int         focus_line = 40;

    task automatic step_lcd_timing(input lcdst_pkg::t_item it, output lcdst_pkg::t_result r);
        logic [7:0]       ly;
        lcdst_pkg::t_mode mode;
        logic             coinc;
        logic             oam_src;
        logic             hblank_src;
        logic             level;
        logic             was_drawing;
        r = '0;
        ly = 8'd0;
        mode = lcdst_pkg::MODE_HBLANK;
        if (!it.lcd_enable) begin
            m_dot = '0;
            m_line = '0;
            m_wrow = '0;
            m_wy_hit = 1'b0;
            m_drawing = 1'b0;
            m_level = it.stat_enables[lcdst_pkg::EN_LYC] && m_lyc_held;
            m_prev = lcdst_pkg::MODE_HBLANK;
            if (!m_cleared) begin
                m_cleared = 1'b1;
                r.panel_blank = 1'b1;
            end
            m_running = 1'b0;
        end else begin
            if (!m_running) begin
                m_running = 1'b1;
                m_cleared = 1'b0;
                m_dot = lcdst_pkg::RESTART_DOT;
                m_first = 1'b1;
            end
            m_dot = m_dot + {2'b00, it.dots};
            if (m_dot >= lcdst_pkg::DOTS_PER_LINE) begin
                m_dot = m_dot - lcdst_pkg::DOTS_PER_LINE;
                m_line = m_line + 8'd1;
                m_first = 1'b0;
                if (m_line >= lcdst_pkg::LINES_PER_FRAME) begin
                    m_line = '0;
                    m_wrow = '0;
                    m_wy_hit = 1'b0;
                end
                if (m_line == lcdst_pkg::FIRST_VBLANK_LINE) begin
                    r.vblank_irq = 1'b1;
                end
            end
            ly = (m_line == lcdst_pkg::LAST_LINE && m_dot >= lcdst_pkg::LY_ZERO_DOT)
                 ? 8'd0 : m_line;
            coinc = (ly == it.lyc_value);
            m_lyc_held = coinc;
            if (m_line < lcdst_pkg::FIRST_VBLANK_LINE && m_dot < lcdst_pkg::OAM_END
                && ly == it.wy_value) begin
                m_wy_hit = 1'b1;
            end
            if (m_line < lcdst_pkg::FIRST_VBLANK_LINE && m_dot == lcdst_pkg::OAM_END) begin
                r.start_line = 1'b1;
                m_drawing = 1'b1;
            end
            was_drawing = m_drawing;
            if (it.dots != 8'd0 && m_line < lcdst_pkg::FIRST_VBLANK_LINE && m_drawing) begin
                r.run_dot = 1'b1;
                if (it.pixel_done) begin
                    m_drawing = 1'b0;
                end
            end
            if (m_line >= lcdst_pkg::FIRST_VBLANK_LINE) begin
                mode = lcdst_pkg::MODE_VBLANK;
            end else if (m_dot < lcdst_pkg::OAM_END) begin
                mode = lcdst_pkg::MODE_OAM;
            end else if (was_drawing) begin
                mode = lcdst_pkg::MODE_DRAW;
            end else begin
                mode = lcdst_pkg::MODE_HBLANK;
            end
            if (m_first && mode == lcdst_pkg::MODE_OAM) begin
                mode = lcdst_pkg::MODE_HBLANK;
            end
            oam_src = (mode == lcdst_pkg::MODE_OAM)
                   || (m_line == lcdst_pkg::FIRST_VBLANK_LINE && m_dot < lcdst_pkg::OAM_END)
                   || (m_colour && m_line == lcdst_pkg::LAST_VISIBLE_LINE
                       && m_dot >= lcdst_pkg::EARLY_OAM_DOT);
            hblank_src = (m_line < lcdst_pkg::FIRST_VBLANK_LINE) && !m_drawing
                         && (m_dot >= lcdst_pkg::OAM_END);
            level = (hblank_src && it.stat_enables[lcdst_pkg::EN_HBLANK])
                 || (mode == lcdst_pkg::MODE_VBLANK && it.stat_enables[lcdst_pkg::EN_VBLANK])
                 || (oam_src && it.stat_enables[lcdst_pkg::EN_OAM])
                 || (coinc && it.stat_enables[lcdst_pkg::EN_LYC]);
            if (it.stat_written && !m_level
                && (hblank_src || mode == lcdst_pkg::MODE_VBLANK || coinc)) begin
                r.stat_irq = 1'b1;
            end
            if (level && !m_level) begin
                r.stat_irq = 1'b1;
            end
            m_level = level;
            if (mode == lcdst_pkg::MODE_HBLANK && m_prev != lcdst_pkg::MODE_HBLANK
                && m_line < lcdst_pkg::FIRST_VBLANK_LINE) begin
                r.hblank_entry = 1'b1;
                if (it.window_used) begin
                    m_wrow = m_wrow + 8'd1;
                end
            end
            m_prev = mode;
        end
        r.line_value = ly;
        r.lcd_mode = mode;
        r.lyc_match = m_lyc_held;
        r.window_row_count = m_wrow;
        r.window_y_latched = m_wy_hit;
    endtask

    task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            n_fail++;
        end
    endtask

    task automatic add_tick(input logic en, input int dots, input int lyc, input int wy,
                            input int ena, input logic wr, input logic done, input logic used);
        lcdst_pkg::t_item it;
        it.lcd_enable = en;
        it.dots = 8'(dots);
        it.lyc_value = 8'(lyc);
        it.wy_value = 8'(wy);
        it.stat_enables = 4'(ena);
        it.stat_written = wr;
        it.pixel_done = done;
        it.window_used = used;
        pending_ticks.push_back(it);
        if (!en) begin
            p_dot = 0;
            p_line = 0;
            p_running = 1'b0;
        end else begin
            if (!p_running) begin
                p_running = 1'b1;
                p_dot = 4;
            end
            p_dot = p_dot + (dots & 255);
            if (p_dot >= 456) begin
                p_dot = p_dot - 456;
                p_line = p_line + 1;
                if (p_line >= 154) begin
                    p_line = 0;
                    focus_line = $urandom_range(141, 2);
                end
            end
        end
    endtask

    // Most items walk the frame in large steps and slow down to at most eight dots around the
    // mode boundaries of the lines that matter; the rest are LCD-off items and noise.
    task automatic add_random_ticks(input int count);
        int   r;
        int   d;
        int   dots;
        int   lyc;
        int   wy;
        int   pick;
        logic zoom;
        logic in_win;
        for (int k = 0; k < count; k++) begin
            r = $urandom_range(999);
            lyc = $urandom_range(255);
            wy = $urandom_range(255);
            pick = $urandom_range(9);
            if (pick == 0) begin
                lyc = p_line;
            end else if (pick == 1) begin
                lyc = p_line + 1;
            end else if (pick == 2) begin
                lyc = 0;
            end else if (pick == 3) begin
                lyc = int'(lcdst_pkg::LAST_LINE);
            end
            pick = $urandom_range(9);
            if (pick < 2) begin
                wy = p_line;
            end else if (pick == 2) begin
                wy = p_line + 1;
            end
            zoom = !p_running || p_line <= 1 || (p_line >= 142 && p_line <= 145)
                || p_line >= 152 || p_line == focus_line;
            in_win = p_dot < 10 || (p_dot >= 74 && p_dot <= 90) || p_dot >= 440;
            if (r < 100) begin
                dots = $urandom_range(255);
            end else if (!zoom) begin
                dots = $urandom_range(255, 200);
            end else if (in_win) begin
                dots = $urandom_range(8);
            end else begin
                d = (p_dot < 74) ? 74 - p_dot : 440 - p_dot;
                if (d > 255) begin
                    dots = $urandom_range(255, 200);
                end else begin
                    dots = d - $urandom_range(d > 4 ? 4 : d - 1);
                end
            end
            add_tick(!(r < 3 || (p_line >= int'(lcdst_pkg::FIRST_VBLANK_LINE) && r < 12)),
                     dots, lyc, wy,
                     $urandom_range(15), $urandom_range(99) < 6, $urandom_range(99) < 25,
                     1'($urandom_range(1)));
        end
    endtask

    task automatic wait_drained();
        while (pending_ticks.size() != 0 || i_in_valid || expected_results.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (8) @(posedge i_clk);
    endtask

    task automatic write_colour_timing(input logic value);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_colour_timing <= value;
        @(posedge i_clk);
        while (!o_cfg_ready) begin
            @(posedge i_clk);
        end
        m_colour = value;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    always @(negedge i_clk) begin : tick_driver
        lcdst_pkg::t_item it;
        logic  idle;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else if (!i_in_valid || in_fire) begin
            idle = !quiet && ($urandom_range(99) < 12);
            if (pending_ticks.size() != 0 && !idle) begin
                it = pending_ticks.pop_front();
                i_in_valid <= 1'b1;
                i_lcd_enable <= it.lcd_enable;
                i_dots <= it.dots;
                i_lyc_value <= it.lyc_value;
                i_wy_value <= it.wy_value;
                i_stat_enables <= it.stat_enables;
                i_stat_written <= it.stat_written;
                i_pixel_done <= it.pixel_done;
                i_window_used <= it.window_used;
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    always @(negedge i_clk) begin : result_receiver
        if (hold_left > 0) begin
            hold_left = hold_left - 1;
            i_out_stall <= 1'b1;
        end else if (!hold_done && n_accepted >= 300) begin
            hold_done = 1'b1;
            hold_left = 150;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= !quiet && ($urandom_range(99) < 12);
        end
    end

    always @(posedge i_clk) begin : result_monitor
        lcdst_pkg::t_item   it;
        lcdst_pkg::t_result predicted;
        lcdst_pkg::t_result want;
        if (!i_rst_n) begin
            in_fire <= 1'b0;
        end else begin
            in_fire <= i_in_valid && !o_in_stall;
            if (i_in_valid && !o_in_stall) begin
                it.lcd_enable = i_lcd_enable;
                it.dots = i_dots;
                it.lyc_value = i_lyc_value;
                it.wy_value = i_wy_value;
                it.stat_enables = i_stat_enables;
                it.stat_written = i_stat_written;
                it.pixel_done = i_pixel_done;
                it.window_used = i_window_used;
                step_lcd_timing(it, predicted);
                expected_results.push_back(predicted);
                n_accepted <= n_accepted + 1;
            end
            if (o_out_valid && !i_out_stall) begin
                if (expected_results.size() == 0) begin
                    $error("result item arrived with no item outstanding");
                    n_fail++;
                end else begin
                    want = expected_results.pop_front();
                    check_field("line_value", want.line_value, o_line_value);
                    check_field("lcd_mode", 8'(want.lcd_mode), 8'(o_lcd_mode));
                    check_field("lyc_match", 8'(want.lyc_match), 8'(o_lyc_match));
                    check_field("vblank_irq", 8'(want.vblank_irq), 8'(o_vblank_irq));
                    check_field("stat_irq", 8'(want.stat_irq), 8'(o_stat_irq));
                    check_field("start_line", 8'(want.start_line), 8'(o_start_line));
                    check_field("run_dot", 8'(want.run_dot), 8'(o_run_dot));
                    check_field("hblank_entry", 8'(want.hblank_entry), 8'(o_hblank_entry));
                    check_field("window_row_count", want.window_row_count, o_window_row_count);
                    check_field("window_y_latched", 8'(want.window_y_latched),
                                8'(o_window_y_latched));
                    check_field("panel_blank", 8'(want.panel_blank), 8'(o_panel_blank));
                end
            end
        end
    end

    initial begin
        #4000000;
        $display("Simulation FAILED");
        $finish;
    end

    initial begin
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // The LCD starts off, comes on and is walked by hand, then goes off and on once more.
        add_tick(1'b0, 0, 0, 0, 4'h8, 1'b0, 1'b0, 1'b0);
        add_tick(1'b0, 255, 255, 255, 4'hF, 1'b1, 1'b1, 1'b1);
        add_tick(1'b1, 0, 0, 0, 4'hF, 1'b1, 1'b0, 1'b0);
        add_tick(1'b1, 77, 255, 0, 4'h4, 1'b0, 1'b0, 1'b0);
        add_tick(1'b1, 1, 255, 0, 4'h1, 1'b0, 1'b1, 1'b0);
        add_tick(1'b1, 1, 255, 0, 4'h1, 1'b0, 1'b0, 1'b1);
        add_tick(1'b1, 255, 1, 0, 4'h0, 1'b0, 1'b0, 1'b0);
        add_tick(1'b1, 255, 1, 0, 4'h8, 1'b0, 1'b0, 1'b0);
        add_tick(1'b1, 0, 0, 1, 4'h0, 1'b0, 1'b0, 1'b0);
        add_tick(1'b1, 0, 0, 1, 4'h0, 1'b1, 1'b0, 1'b0);
        add_tick(1'b1, 255, 2, 2, 4'h3, 1'b0, 1'b1, 1'b1);
        add_tick(1'b1, 255, 255, 255, 4'hF, 1'b1, 1'b1, 1'b1);
        add_tick(1'b1, 200, 3, 3, 4'h2, 1'b0, 1'b0, 1'b0);
        add_tick(1'b0, 10, 0, 0, 4'h8, 1'b1, 1'b0, 1'b0);
        add_tick(1'b1, 76, 0, 0, 4'h5, 1'b0, 1'b0, 1'b0);
        add_tick(1'b1, 1, 0, 0, 4'h5, 1'b0, 1'b0, 1'b0);
        add_tick(1'b1, 0, 0, 0, 4'h5, 1'b0, 1'b1, 1'b0);
        add_tick(1'b1, 3, 0, 0, 4'h5, 1'b0, 1'b1, 1'b1);
        wait_drained();

        write_colour_timing(1'b1);
        add_random_ticks(550);
        wait_drained();

        write_colour_timing(1'b0);
        add_random_ticks(400);
        wait_drained();

        write_colour_timing(1'b1);
        add_random_ticks(450);
        wait_drained();

        if (n_fail == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
